>>> rtl/core/bums_pkg.sv
// Package for the bottom-up merge sorter.
// Holds the data word width and the sequencer state type; depends on nothing.
package bums_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_PASS = 7'b0000010,
        S_RUN  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_ORD  = 7'b0100000,
        S_OVAL = 7'b1000000
    } t_state;

endpackage

>>> rtl/core/bottom_up_merge_sort.sv
// Bottom-up merge sorter. Load: one word per cycle until last (stall high otherwise).
// Sort: ceil(log2 n) passes over one shared compare unit; each element is read from
// registered RAM (S_RD) and merged (S_CMP); each run pair and pass adds a state.
// Output: words are read, then held while stalled; next set loads after the last word.
// Reset (synchronous, active low) clears count, overflow flag and sequencer; the
// RAM is not cleared and only entries written in the current set are read.
module bottom_up_merge_sort #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [bums_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bums_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                                o_last_res,
    output logic                                o_overflow
);
    import bums_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 2;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    t_state r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [WW-1:0] r_width, n_width;
    logic [WW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_q, n_q;
    logic [CW-1:0] r_k, n_k;

    logic              we;
    logic [AW:0]       waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rd0, rd1;
    logic              accept;
    logic              take_left;
    logic [WW-1:0]     rem_lo;
    logic [CW-1:0]     mid_c;
    logic [WW-1:0]     rem_mid;

    bums_ram #(
        .DEPTH(2 ** (AW + 1))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr0({r_src, r_p[AW-1:0]}),
        .i_raddr1({r_src, r_q[AW-1:0]}),
        .o_rdata0(rd0),
        .o_rdata1(rd1)
    );

    assign accept    = (r_state == S_LOAD) && i_valid;
    assign take_left = (r_p < r_mid) &&
                       ((r_q >= r_hi) || ($signed(rd0) <= $signed(rd1)));

    // Run bounds: clip the left and right runs to the item count.
    assign rem_lo  = {2'b00, r_n} - r_lo;
    assign mid_c   = (rem_lo > r_width) ? CW'(r_lo + r_width) : r_n;
    assign rem_mid = {2'b00, r_n} - {2'b00, mid_c};

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_p     = r_p;
        n_q     = r_q;
        n_k     = r_k;
        we      = 1'b0;
        waddr   = {1'b0, r_n[AW-1:0]};
        wdata   = i_value;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_n < MAX_C) begin
                        we  = 1'b1;
                        n_n = r_n + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_width = WW'(1);
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (r_width >= {2'b00, r_n}) begin
                    n_p     = '0;
                    n_state = S_ORD;
                end else begin
                    n_lo    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_lo >= {2'b00, r_n}) begin
                    // pass done: double the width, swap banks
                    n_width = r_width << 1;
                    n_src   = ~r_src;
                    n_state = S_PASS;
                end else begin
                    n_mid   = mid_c;
                    n_hi    = (rem_mid > r_width) ? CW'({2'b00, mid_c} + r_width) : r_n;
                    n_p     = CW'(r_lo);
                    n_q     = mid_c;
                    n_k     = CW'(r_lo);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                we    = 1'b1;
                waddr = {~r_src, r_k[AW-1:0]};
                wdata = take_left ? rd0 : rd1;
                n_k   = r_k + CW'(1);
                if (take_left) begin
                    n_p = r_p + CW'(1);
                end else begin
                    n_q = r_q + CW'(1);
                end
                if ((r_k + CW'(1)) == r_hi) begin
                    n_lo    = r_lo + (r_width << 1);
                    n_state = S_RUN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                n_state = S_OVAL;
            end
            S_OVAL: begin
                if (!i_stall) begin
                    if (o_last_res) begin
                        n_n     = '0;
                        n_ovf   = 1'b0;
                        n_src   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_p     = r_p + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_p     <= n_p;
        r_q     <= n_q;
        r_k     <= n_k;
    end

    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = (r_state == S_OVAL);
    assign o_sorted_value = $signed(rd0);
    assign o_last_res     = ((r_p + CW'(1)) == r_n);
    assign o_overflow     = r_ovf;

endmodule

>>> rtl/core/bums_ram.sv
// Storage RAM for the merge sorter: one write port, two registered read ports.
// Depends on bums_pkg for the word width.
module bums_ram #(
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [bums_pkg::DATA_W-1:0]      i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr0,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr1,
    output logic [bums_pkg::DATA_W-1:0]      o_rdata0,
    output logic [bums_pkg::DATA_W-1:0]      o_rdata1
);
    import bums_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd0;
    logic [DATA_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

>>> tb/sv/bottom_up_merge_sort_test.sv
// Testbench for bottom_up_merge_sort: directed data sets, then random data sets
// checked against a merge-sort predictor. Depends on bums_pkg and the sorter RTL.
module bottom_up_merge_sort_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bums_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 120;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EDGE
    } t_value_mix;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_word;

    // typed rows close a one-word set, so the sorted word is the input word
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_value;
    } t_stim_row;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last  = 1'b0;
    logic                     i_stall = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_last_res;
    logic                     o_overflow;

    // predictor state
    logic signed [DATA_W-1:0] load_words [CAPACITY];
    int                       load_count   = 0;
    logic                     dropped_seen = 1'b0;

    t_sorted_word sorted_batch[$];
    t_sorted_word sorted_expected[$];
    t_stim_row    directed[$];

    int errors      = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_tick  = 0;

    bottom_up_merge_sort #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sorted_value(o_sorted_value),
        .o_last_res    (o_last_res),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Load one word; on last, sort the set into sorted_batch and start over.
    function void load_and_sort(input logic signed [DATA_W-1:0] v, input logic l);
        logic signed [DATA_W-1:0] src [CAPACITY];
        logic signed [DATA_W-1:0] dst [CAPACITY];
        t_sorted_word sw;
        int n, w, lo, mid, hi, p, q, k;
        sorted_batch.delete();
        if (load_count < CAPACITY) begin
            load_words[load_count] = v;
            load_count++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (!l)
            return;
        n = load_count;
        src = load_words;
        for (w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo < n; lo = lo + 2 * w) begin
                // clip the trailing runs to the count
                mid = (n - lo > w) ? lo + w : n;
                hi = (n - mid > w) ? mid + w : n;
                p = lo;
                q = mid;
                k = lo;
                while (p < mid && q < hi) begin
                    if (src[p] <= src[q]) begin
                        dst[k] = src[p];
                        p++;
                    end else begin
                        dst[k] = src[q];
                        q++;
                    end
                    k++;
                end
                while (p < mid) begin
                    dst[k] = src[p];
                    p++;
                    k++;
                end
                while (q < hi) begin
                    dst[k] = src[q];
                    q++;
                    k++;
                end
            end
            src = dst;
        end
        for (k = 0; k < n; k++) begin
            sw.value = src[k];
            sw.last  = (k == n - 1);
            sw.ovf   = dropped_seen;
            sorted_batch.push_back(sw);
        end
        load_count = 0;
        dropped_seen = 1'b0;
    endfunction

    function t_stim_row mk_row(input logic signed [DATA_W-1:0] v, input logic l,
                               input logic typed, input logic signed [DATA_W-1:0] ev);
        t_stim_row r;
        r.value = v;
        r.last = l;
        r.typed = typed;
        r.exp_value = ev;
        return r;
    endfunction

    function logic signed [DATA_W-1:0] pick_value(input t_value_mix mix);
        logic signed [DATA_W-1:0] v;
        case (mix)
            VAL_NARROW: v = $signed($urandom_range(0, 6)) - 3;
            VAL_EDGE: begin
                case ($urandom_range(0, 4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one word, hold it until accepted, then pace the next burst.
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic l,
                             input logic typed, input logic signed [DATA_W-1:0] ev);
        t_sorted_word sw;
        i_value <= v;
        i_last  <= l;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        load_and_sort(v, l);
        if (typed) begin
            sw.value = ev;
            sw.last  = 1'b1;
            sw.ovf   = 1'b0;
            sorted_expected.push_back(sw);
        end else begin
            while (sorted_batch.size() > 0)
                sorted_expected.push_back(sorted_batch.pop_front());
        end
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 11);
        end
    endtask

    // receiver stall pattern, with a random mode redrawn on a stall_tick schedule
    always @(negedge i_clk) begin
        if (stall_tick % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            3: i_stall <= ((stall_tick % 8) < 5);
            default: i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sorted_expected.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %0d last %0b ovf %0b",
                         $time, o_sorted_value, o_last_res, o_overflow);
                errors++;
            end else begin
                want = sorted_expected.pop_front();
                if (o_sorted_value !== want.value) begin
                    $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                             $time, $signed(want.value), o_sorted_value);
                    errors++;
                end
                if (o_last_res !== want.last) begin
                    $display("%0t: last_res mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last_res);
                    errors++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow mismatch: expected %0b, actual %0b",
                             $time, want.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    // watchdog: end the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int set_idx;
        int set_len;
        int random_items;
        t_value_mix mix;

        // one-word sets at the extremes and around zero
        directed.push_back(mk_row(VAL_MIN, 1'b1, 1'b1, VAL_MIN));
        directed.push_back(mk_row(VAL_MAX, 1'b1, 1'b1, VAL_MAX));
        directed.push_back(mk_row(0, 1'b1, 1'b1, 0));
        directed.push_back(mk_row(-1, 1'b1, 1'b1, -1));
        // mixed signs
        directed.push_back(mk_row(3, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(-1, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(2, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(0, 1'b1, 1'b0, 0));
        // extremes in one set
        directed.push_back(mk_row(VAL_MAX, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(VAL_MIN, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(-1, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(0, 1'b1, 1'b0, 0));
        // ties, odd count so the last run is clipped
        directed.push_back(mk_row(7, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(-7, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(7, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(7, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(-7, 1'b1, 1'b0, 0));
        // descending input
        directed.push_back(mk_row(30, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(20, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(10, 1'b1, 1'b0, 0));
        // equal pair
        directed.push_back(mk_row(5, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(5, 1'b1, 1'b0, 0));
        // alternating bit patterns
        directed.push_back(mk_row(32'sh5555_5555, 1'b0, 1'b0, 0));
        directed.push_back(mk_row(32'shAAAA_AAAA, 1'b1, 1'b0, 0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < directed.size(); r++)
            send_word(directed[r].value, directed[r].last, directed[r].typed,
                      directed[r].exp_value);

        // random sets; set 1 fills the store exactly, set 3 overruns it
        set_idx = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || set_idx < 4) begin
            if (set_idx == 1)
                set_len = CAPACITY;
            else if (set_idx == 3)
                set_len = CAPACITY + $urandom_range(1, 4);
            else if ($urandom_range(0, 99) < 65)
                set_len = $urandom_range(1, 8);
            else if ($urandom_range(0, 99) < 70)
                set_len = $urandom_range(9, 24);
            else
                set_len = $urandom_range(25, CAPACITY - 1);
            mix = t_value_mix'($urandom_range(0, 2));
            for (int j = 0; j < set_len; j++)
                send_word(pick_value(mix), (j == set_len - 1), 1'b0, '0);
            random_items += set_len;
            set_idx++;
        end
        i_valid <= 1'b0;

        while (sorted_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> bottom_up_merge_sort.f
rtl/core/bums_pkg.sv
rtl/core/bums_ram.sv
rtl/core/bottom_up_merge_sort.sv
tb/sv/bottom_up_merge_sort_test.sv
